// ===== design/amaf_pkg.sv =====
package amaf_pkg;

	// switch positions
	localparam logic [1:0] POS_CENTER = 2'd0;
	localparam logic [1:0] POS_LOW    = 2'd1;
	localparam logic [1:0] POS_HIGH   = 2'd2;

	// track directions
	typedef logic signed [1:0] dir_t;
	localparam dir_t DIR_NONE    = 2'sd0;
	localparam dir_t DIR_EXTEND  = 2'sd1;
	localparam dir_t DIR_RETRACT = -2'sd1;

	// owner codes
	localparam logic [1:0] OWN_NONE      = 2'd0;
	localparam logic [1:0] OWN_TRACK     = 2'd1;
	localparam logic [1:0] OWN_HYDRAULIC = 2'd2;
	localparam logic [1:0] OWN_CLEARANCE = 2'd3;

	// adjust state codes as reported
	localparam logic [2:0] ADJ_IDLE      = 3'd0;
	localparam logic [2:0] ADJ_ABORTED   = 3'd1;
	localparam logic [2:0] ADJ_PREPARE   = 3'd2;
	localparam logic [2:0] ADJ_ACTIVE    = 3'd3;
	localparam logic [2:0] ADJ_EXITING   = 3'd4;
	localparam logic [2:0] ADJ_READY     = 3'd5;
	localparam logic [2:0] ADJ_HYDRAULIC = 3'd6;
	localparam logic [2:0] ADJ_CLEARANCE = 3'd7;

	localparam logic DIAG_OK    = 1'b0;
	localparam logic DIAG_ABORT = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_EXTEND_ENGAGE   = 3'd0,
		CFG_EXTEND_RELEASE  = 3'd1,
		CFG_RETRACT_ENGAGE  = 3'd2,
		CFG_RETRACT_RELEASE = 3'd3,
		CFG_STABLE_TIME     = 3'd4,
		CFG_CENTER_EXIT     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [10:0] extend_engage;
		logic signed [10:0] extend_release;
		logic signed [10:0] retract_engage;
		logic signed [10:0] retract_release;
	} thresh_cfg_t;

	typedef struct packed {
		dir_t latched;
		dir_t candidate;
	} track_dirs_t;

	// input beat, last field in the lowest bits
	typedef struct packed {
		logic               severe_fault;
		logic               estop_active;
		logic               throttle_is_low;
		logic               at_zero_speed;
		logic               park_selected;
		logic               rear_select;
		logic               front_select;
		logic signed [10:0] track_value;
		logic [1:0]         gear_pos;
		logic [1:0]         clearance_pos;
		logic [1:0]         home_pos;
		logic [31:0]        now_ms;
	} item_t;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic       diag_code;
		dir_t       accepted_direction;
		logic       suspension_rear;
		logic [1:0] owner;
		logic [2:0] adjust_state;
	} result_t;

endpackage

// ===== design/amaf_dir_filter.sv =====
module amaf_dir_filter #(
	parameter int TIME_WIDTH = 32
) (
	input  logic signed [10:0]     track_value,
	input  logic [TIME_WIDTH-1:0]  now_w,
	input  amaf_pkg::thresh_cfg_t  thresh,
	input  logic [15:0]            stable_time_ms,
	input  amaf_pkg::track_dirs_t  dirs_q,
	input  logic [TIME_WIDTH-1:0]  stamp_q,
	output amaf_pkg::track_dirs_t  dirs_d,
	output logic [TIME_WIDTH-1:0]  stamp_d,
	output amaf_pkg::dir_t         dir
);

	logic signed [10:0]      ext_eng, ext_rel, ret_eng, ret_rel;
	amaf_pkg::dir_t          raw;
	logic [TIME_WIDTH+15:0]  stable_ext;
	logic [TIME_WIDTH-1:0]   stable_w;
	logic [TIME_WIDTH-1:0]   held;

	assign ext_eng = $signed(thresh.extend_engage);
	assign ext_rel = $signed(thresh.extend_release);
	assign ret_eng = $signed(thresh.retract_engage);
	assign ret_rel = $signed(thresh.retract_release);

	assign stable_ext = {{TIME_WIDTH{1'b0}}, stable_time_ms};
	assign stable_w   = stable_ext[TIME_WIDTH-1:0];
	assign held       = now_w - stamp_q;

	// hysteresis: a latched direction releases at the looser threshold
	always_comb begin
		if (dirs_q.latched == amaf_pkg::DIR_EXTEND && track_value >= ext_rel) begin
			raw = amaf_pkg::DIR_EXTEND;
		end else if (dirs_q.latched == amaf_pkg::DIR_RETRACT && track_value <= ret_rel) begin
			raw = amaf_pkg::DIR_RETRACT;
		end else if (track_value >= ext_eng) begin
			raw = amaf_pkg::DIR_EXTEND;
		end else if (track_value <= ret_eng) begin
			raw = amaf_pkg::DIR_RETRACT;
		end else begin
			raw = amaf_pkg::DIR_NONE;
		end
	end

	// persistence check
	always_comb begin
		dirs_d  = dirs_q;
		stamp_d = stamp_q;
		dir     = amaf_pkg::DIR_NONE;
		if (raw == amaf_pkg::DIR_NONE) begin
			dirs_d.latched   = amaf_pkg::DIR_NONE;
			dirs_d.candidate = amaf_pkg::DIR_NONE;
			stamp_d          = '0;
		end else if (dirs_q.latched == raw) begin
			dirs_d.candidate = raw;
			stamp_d          = now_w;
			dir              = raw;
		end else if (dirs_q.candidate != raw) begin
			dirs_d.candidate = raw;
			stamp_d          = now_w;
		end else if (held >= stable_w) begin
			dirs_d.latched = raw;
			dir            = raw;
		end
	end

endmodule

// ===== design/amaf_mode_core.sv =====
module amaf_mode_core #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  amaf_pkg::item_t       item,
	input  amaf_pkg::thresh_cfg_t thresh,
	input  logic [15:0]           stable_time_ms,
	input  logic [15:0]           center_exit_ms,
	output amaf_pkg::result_t     result_d
);

	typedef enum logic [2:0] {
		S_IDLE      = amaf_pkg::ADJ_IDLE,
		S_ABORTED   = amaf_pkg::ADJ_ABORTED,
		S_PREPARE   = amaf_pkg::ADJ_PREPARE,
		S_ACTIVE    = amaf_pkg::ADJ_ACTIVE,
		S_EXITING   = amaf_pkg::ADJ_EXITING,
		S_READY     = amaf_pkg::ADJ_READY,
		S_HYDRAULIC = amaf_pkg::ADJ_HYDRAULIC,
		S_CLEARANCE = amaf_pkg::ADJ_CLEARANCE
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [1:0]             owner_q, owner_d;
	logic                   rear_q, rear_d;
	logic                   diag_q, diag_d;
	amaf_pkg::track_dirs_t  dirs_q, dirs_d, f_dirs;
	logic [TIME_WIDTH-1:0]  rstamp_q, rstamp_d, f_stamp;
	logic [TIME_WIDTH-1:0]  cstamp_q, cstamp_d, cs_sel;
	amaf_pkg::dir_t         f_dir;

	logic [TIME_WIDTH+31:0] now_ext;
	logic [TIME_WIDTH-1:0]  now_w;
	logic [TIME_WIDTH+15:0] exit_ext;
	logic [TIME_WIDTH-1:0]  exit_w;
	logic                   entering, pre_ok, clr_act, susp_act, exit_done;

	assign now_ext  = {{TIME_WIDTH{1'b0}}, item.now_ms};
	assign now_w    = now_ext[TIME_WIDTH-1:0];
	assign exit_ext = {{TIME_WIDTH{1'b0}}, center_exit_ms};
	assign exit_w   = exit_ext[TIME_WIDTH-1:0];

	amaf_dir_filter #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_dir (
		.track_value   (item.track_value),
		.now_w         (now_w),
		.thresh        (thresh),
		.stable_time_ms(stable_time_ms),
		.dirs_q        (dirs_q),
		.stamp_q       (rstamp_q),
		.dirs_d        (f_dirs),
		.stamp_d       (f_stamp),
		.dir           (f_dir)
	);

	assign entering = (mode_q == S_IDLE) || (mode_q == S_ABORTED);
	assign pre_ok   = item.park_selected && (!entering || item.at_zero_speed) &&
	                  item.throttle_is_low && !item.estop_active && !item.severe_fault;
	assign clr_act  = (item.clearance_pos == amaf_pkg::POS_LOW) ||
	                  (item.clearance_pos == amaf_pkg::POS_HIGH);
	assign susp_act = (item.gear_pos == amaf_pkg::POS_LOW) ||
	                  (item.gear_pos == amaf_pkg::POS_HIGH);

	// zero stamp means not taken yet
	assign cs_sel    = (cstamp_q == '0) ? now_w : cstamp_q;
	assign exit_done = (now_w - cs_sel) >= exit_w;

	always_comb begin
		mode_d   = mode_q;
		owner_d  = owner_q;
		rear_d   = rear_q;
		diag_d   = diag_q;
		dirs_d   = dirs_q;
		rstamp_d = rstamp_q;
		cstamp_d = cstamp_q;
		if (item.home_pos != amaf_pkg::POS_CENTER) begin
			mode_d           = S_IDLE;
			owner_d          = amaf_pkg::OWN_NONE;
			cstamp_d         = '0;
			dirs_d.latched   = amaf_pkg::DIR_NONE;
			dirs_d.candidate = amaf_pkg::DIR_NONE;
			rstamp_d         = '0;
			diag_d           = amaf_pkg::DIAG_OK;
		end else if (!pre_ok) begin
			mode_d           = S_ABORTED;
			owner_d          = amaf_pkg::OWN_NONE;
			cstamp_d         = '0;
			dirs_d.latched   = amaf_pkg::DIR_NONE;
			dirs_d.candidate = amaf_pkg::DIR_NONE;
			rstamp_d         = '0;
			diag_d           = amaf_pkg::DIAG_ABORT;
		end else begin
			if (item.rear_select) begin
				rear_d = 1'b1;
			end else if (item.front_select) begin
				rear_d = 1'b0;
			end
			dirs_d   = f_dirs;
			rstamp_d = f_stamp;
			diag_d   = amaf_pkg::DIAG_OK;
			if (f_dir != amaf_pkg::DIR_NONE) begin
				cstamp_d = '0;
				if (owner_q != amaf_pkg::OWN_TRACK) begin
					owner_d = amaf_pkg::OWN_TRACK;
					mode_d  = S_PREPARE;
				end else begin
					mode_d = S_ACTIVE;
				end
			end else if (owner_q == amaf_pkg::OWN_TRACK &&
			             f_dirs.latched == amaf_pkg::DIR_NONE) begin
				if (exit_done) begin
					owner_d          = amaf_pkg::OWN_NONE;
					cstamp_d         = '0;
					dirs_d.latched   = amaf_pkg::DIR_NONE;
					dirs_d.candidate = amaf_pkg::DIR_NONE;
					rstamp_d         = '0;
					mode_d           = S_READY;
				end else begin
					cstamp_d = cs_sel;
					mode_d   = S_EXITING;
				end
			end else if (!clr_act && !susp_act) begin
				// a zero candidate here means the filter already cleared the track regs
				owner_d  = amaf_pkg::OWN_NONE;
				mode_d   = S_READY;
				cstamp_d = '0;
			end else begin
				cstamp_d         = '0;
				dirs_d.latched   = amaf_pkg::DIR_NONE;
				dirs_d.candidate = amaf_pkg::DIR_NONE;
				rstamp_d         = '0;
				if (susp_act) begin
					owner_d = amaf_pkg::OWN_HYDRAULIC;
					mode_d  = S_HYDRAULIC;
				end else begin
					owner_d = amaf_pkg::OWN_CLEARANCE;
					mode_d  = S_CLEARANCE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= S_IDLE;
			owner_q  <= amaf_pkg::OWN_NONE;
			rear_q   <= 1'b0;
			diag_q   <= amaf_pkg::DIAG_OK;
			dirs_q   <= '0;
			rstamp_q <= '0;
			cstamp_q <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			owner_q  <= owner_d;
			rear_q   <= rear_d;
			diag_q   <= diag_d;
			dirs_q   <= dirs_d;
			rstamp_q <= rstamp_d;
			cstamp_q <= cstamp_d;
		end
	end

	assign result_d.adjust_state       = mode_d;
	assign result_d.owner              = owner_d;
	assign result_d.suspension_rear    = rear_d;
	assign result_d.accepted_direction = dirs_d.latched;
	assign result_d.diag_code          = diag_d;

endmodule

// ===== design/adjust_mode_arbiter_fsm_core.sv =====
// Channel   Dir  Beat content
// s_axis    in   one periodic update (switches, track wheel, preconditions, time)
// m_axis    out  adjust state, owner, suspension target, direction, diag
// cfg       in   register write: cfg_wr_en, cfg_index, cfg_data
//
// One beat per cycle sustained while m_axis is ready; each update passes through
// the input register, then the result register. The arbiter state advances in the
// same edge that loads the result register, so back-to-back beats see the
// state left by the one before. A stalled m_axis holds the result; the input
// register still takes one more beat before s_axis_tready drops.
// Reset puts the valid flags, config and arbiter state to their defaults at once, no sweep.
module adjust_mode_arbiter_fsm_core #(
	parameter int TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] now_ms, [33:32] home_pos, [35:34] clearance_pos, [37:36] gear_pos,
	// [48:38] track_value, [49] front_select, [50] rear_select, [51] park_selected,
	// [52] at_zero_speed, [53] throttle_is_low, [54] estop_active, [55] severe_fault
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] adjust_state, [4:3] owner, [5] suspension_rear,
	// [7:6] accepted_direction, [8] diag_code, [15:9] zero
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	amaf_pkg::thresh_cfg_t thresh_q;
	logic [15:0]           stable_q;
	logic [15:0]           exit_q;

	// input stage and result stage
	logic                  valid_s1;
	amaf_pkg::item_t       item_s1;
	logic                  valid_s2;
	amaf_pkg::result_t     result_s2;
	amaf_pkg::result_t     result_d;
	logic                  advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.extend_engage   <= 11'sd500;
			thresh_q.extend_release  <= 11'sd300;
			thresh_q.retract_engage  <= -11'sd500;
			thresh_q.retract_release <= -11'sd300;
			stable_q                 <= 16'd100;
			exit_q                   <= 16'd200;
		end else if (cfg_wr_en) begin
			case (amaf_pkg::cfg_idx_t'(cfg_index))
				amaf_pkg::CFG_EXTEND_ENGAGE:   thresh_q.extend_engage   <= cfg_data[10:0];
				amaf_pkg::CFG_EXTEND_RELEASE:  thresh_q.extend_release  <= cfg_data[10:0];
				amaf_pkg::CFG_RETRACT_ENGAGE:  thresh_q.retract_engage  <= cfg_data[10:0];
				amaf_pkg::CFG_RETRACT_RELEASE: thresh_q.retract_release <= cfg_data[10:0];
				amaf_pkg::CFG_STABLE_TIME:     stable_q                 <= cfg_data;
				amaf_pkg::CFG_CENTER_EXIT:     exit_q                   <= cfg_data;
				default: ;
			endcase
		end
	end

	// the input register drains whenever the result register is free or emptying
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= amaf_pkg::item_t'(s_axis_tdata);
		end
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	amaf_mode_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.thresh        (thresh_q),
		.stable_time_ms(stable_q),
		.center_exit_ms(exit_q),
		.result_d      (result_d)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, result_s2};

`ifndef SYNTH
	// an abort always reports with no owner
	a_diag_abort: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.diag_code == amaf_pkg::DIAG_ABORT) |->
		(result_s2.adjust_state == amaf_pkg::ADJ_ABORTED &&
		 result_s2.owner == amaf_pkg::OWN_NONE))
		else $error("abort reported with wrong state or owner");

	// track owner exactly in the three track states
	a_track_owner: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |->
		((result_s2.owner == amaf_pkg::OWN_TRACK) ==
		 (result_s2.adjust_state == amaf_pkg::ADJ_PREPARE ||
		  result_s2.adjust_state == amaf_pkg::ADJ_ACTIVE ||
		  result_s2.adjust_state == amaf_pkg::ADJ_EXITING)))
		else $error("track owner and adjust state disagree");

	// a waiting beat moves into a free result register
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (!valid_s2 || m_axis_tready)) |=> valid_s2)
		else $error("input beat not forwarded");

	// direction code never takes the unused pattern
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.accepted_direction != 2'sb10))
		else $error("invalid direction code");
`endif

endmodule

// ===== tb/adjust_mode_arbiter_fsm_monitor.sv =====
module adjust_mode_arbiter_fsm_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	logic signed [10:0] ext_eng_q, ext_rel_q, ret_eng_q, ret_rel_q;
	logic [15:0]        stable_q, exit_q;

	// arbiter state copy
	logic [2:0]      mode_q;
	logic [1:0]      owner_q;
	logic            rear_q, diag_q;
	amaf_pkg::dir_t  latched_q, cand_q;
	logic [31:0]     req_stamp_q, exit_stamp_q;

	amaf_pkg::result_t pending_results [$];
	amaf_pkg::result_t want, got;
	int                mismatches = 0;
	int                result_no = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(string what, int got_v, int want_v);
		mismatches++;
		$display("result %0d: %s is %0d, expected %0d", result_no, what, got_v, want_v);
	endtask

	function automatic void drop_track();
		latched_q   = amaf_pkg::DIR_NONE;
		cand_q      = amaf_pkg::DIR_NONE;
		req_stamp_q = '0;
	endfunction

	// hysteresis: a latched direction is held down to its release level
	function automatic amaf_pkg::dir_t wheel_request(logic signed [10:0] tv);
		if (latched_q == amaf_pkg::DIR_EXTEND && tv >= ext_rel_q) return amaf_pkg::DIR_EXTEND;
		if (latched_q == amaf_pkg::DIR_RETRACT && tv <= ret_rel_q) return amaf_pkg::DIR_RETRACT;
		if (tv >= ext_eng_q) return amaf_pkg::DIR_EXTEND;
		if (tv <= ret_eng_q) return amaf_pkg::DIR_RETRACT;
		return amaf_pkg::DIR_NONE;
	endfunction

	// a new direction must persist for stable_q ms before it latches
	function automatic amaf_pkg::dir_t settle_direction(logic signed [10:0] tv,
			logic [31:0] now);
		amaf_pkg::dir_t req;
		req = wheel_request(tv);
		if (req == amaf_pkg::DIR_NONE) begin
			drop_track();
			return amaf_pkg::DIR_NONE;
		end
		if (latched_q == req) begin
			cand_q      = req;
			req_stamp_q = now;
			return req;
		end
		if (cand_q != req) begin
			cand_q      = req;
			req_stamp_q = now;
			return amaf_pkg::DIR_NONE;
		end
		if (now - req_stamp_q >= {16'd0, stable_q}) begin
			latched_q = req;
			return req;
		end
		return amaf_pkg::DIR_NONE;
	endfunction

	function automatic amaf_pkg::result_t advance_arbiter(amaf_pkg::item_t u);
		amaf_pkg::result_t r;
		amaf_pkg::dir_t    d;
		logic              entering, clr_act, susp_act;
		if (u.home_pos != amaf_pkg::POS_CENTER) begin
			mode_q       = amaf_pkg::ADJ_IDLE;
			owner_q      = amaf_pkg::OWN_NONE;
			exit_stamp_q = '0;
			drop_track();
			diag_q       = amaf_pkg::DIAG_OK;
		end else begin
			entering = (mode_q == amaf_pkg::ADJ_IDLE) || (mode_q == amaf_pkg::ADJ_ABORTED);
			if (!(u.park_selected && (!entering || u.at_zero_speed) && u.throttle_is_low &&
					!u.estop_active && !u.severe_fault)) begin
				mode_q       = amaf_pkg::ADJ_ABORTED;
				owner_q      = amaf_pkg::OWN_NONE;
				exit_stamp_q = '0;
				drop_track();
				diag_q       = amaf_pkg::DIAG_ABORT;
			end else begin
				if (u.front_select) rear_q = 1'b0;
				if (u.rear_select) rear_q = 1'b1;
				clr_act  = (u.clearance_pos == amaf_pkg::POS_LOW) ||
					(u.clearance_pos == amaf_pkg::POS_HIGH);
				susp_act = (u.gear_pos == amaf_pkg::POS_LOW) ||
					(u.gear_pos == amaf_pkg::POS_HIGH);
				d        = settle_direction(u.track_value, u.now_ms);
				diag_q   = amaf_pkg::DIAG_OK;
				if (d != amaf_pkg::DIR_NONE) begin
					exit_stamp_q = '0;
					mode_q       = (owner_q == amaf_pkg::OWN_TRACK) ?
						amaf_pkg::ADJ_ACTIVE : amaf_pkg::ADJ_PREPARE;
					owner_q      = amaf_pkg::OWN_TRACK;
				end else if (owner_q == amaf_pkg::OWN_TRACK &&
						latched_q == amaf_pkg::DIR_NONE) begin
					// zero stamp means none taken yet
					if (exit_stamp_q == '0) exit_stamp_q = u.now_ms;
					mode_q = amaf_pkg::ADJ_EXITING;
					if (u.now_ms - exit_stamp_q >= {16'd0, exit_q}) begin
						owner_q      = amaf_pkg::OWN_NONE;
						exit_stamp_q = '0;
						drop_track();
						mode_q       = amaf_pkg::ADJ_READY;
					end
				end else if (!clr_act && !susp_act) begin
					owner_q      = amaf_pkg::OWN_NONE;
					mode_q       = amaf_pkg::ADJ_READY;
					exit_stamp_q = '0;
					if (cand_q == amaf_pkg::DIR_NONE) drop_track();
				end else begin
					exit_stamp_q = '0;
					drop_track();
					if (susp_act) begin
						owner_q = amaf_pkg::OWN_HYDRAULIC;
						mode_q  = amaf_pkg::ADJ_HYDRAULIC;
					end else begin
						owner_q = amaf_pkg::OWN_CLEARANCE;
						mode_q  = amaf_pkg::ADJ_CLEARANCE;
					end
				end
			end
		end
		r.adjust_state       = mode_q;
		r.owner              = owner_q;
		r.suspension_rear    = rear_q;
		r.accepted_direction = latched_q;
		r.diag_code          = diag_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_eng_q    = 11'sd500;
			ext_rel_q    = 11'sd300;
			ret_eng_q    = -11'sd500;
			ret_rel_q    = -11'sd300;
			stable_q     = 16'd100;
			exit_q       = 16'd200;
			mode_q       = amaf_pkg::ADJ_IDLE;
			owner_q      = amaf_pkg::OWN_NONE;
			rear_q       = 1'b0;
			diag_q       = amaf_pkg::DIAG_OK;
			latched_q    = amaf_pkg::DIR_NONE;
			cand_q       = amaf_pkg::DIR_NONE;
			req_stamp_q  = '0;
			exit_stamp_q = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					amaf_pkg::CFG_EXTEND_ENGAGE:   ext_eng_q = $signed(cfg_data[10:0]);
					amaf_pkg::CFG_EXTEND_RELEASE:  ext_rel_q = $signed(cfg_data[10:0]);
					amaf_pkg::CFG_RETRACT_ENGAGE:  ret_eng_q = $signed(cfg_data[10:0]);
					amaf_pkg::CFG_RETRACT_RELEASE: ret_rel_q = $signed(cfg_data[10:0]);
					amaf_pkg::CFG_STABLE_TIME:     stable_q  = cfg_data;
					amaf_pkg::CFG_CENTER_EXIT:     exit_q    = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(advance_arbiter(amaf_pkg::item_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = amaf_pkg::result_t'(m_axis_tdata[8:0]);
				if (pending_results.size() == 0) begin
					report_mismatch("beat with nothing pending", int'(m_axis_tdata), 0);
				end else begin
					want = pending_results.pop_front();
					if (got.adjust_state !== want.adjust_state)
						report_mismatch("adjust_state", int'(got.adjust_state),
							int'(want.adjust_state));
					if (got.owner !== want.owner)
						report_mismatch("owner", int'(got.owner), int'(want.owner));
					if (got.suspension_rear !== want.suspension_rear)
						report_mismatch("suspension_rear", int'(got.suspension_rear),
							int'(want.suspension_rear));
					if (got.accepted_direction !== want.accepted_direction)
						report_mismatch("accepted_direction", int'(got.accepted_direction),
							int'(want.accepted_direction));
					if (got.diag_code !== want.diag_code)
						report_mismatch("diag_code", int'(got.diag_code),
							int'(want.diag_code));
				end
				if (m_axis_tdata[15:9] !== '0)
					report_mismatch("padding", int'(m_axis_tdata[15:9]), 0);
				result_no++;
			end
			outstanding <= outstanding + int'(s_axis_tvalid && s_axis_tready)
				- int'(m_axis_tvalid && m_axis_tready);
		end
	end

endmodule

// ===== tb/adjust_mode_arbiter_fsm_core_tb.sv =====
module adjust_mode_arbiter_fsm_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] POS_OTHER     = 2'd3;
	localparam logic [2:0] CFG_SPARE_IDX = 3'd7;   // no register here, write must be dropped
	localparam int         RUN_LIMIT     = 500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int fail_count;
	int outstanding;
	int cycles = 0;

	// sender burst bookkeeping
	int burst_left = 0;

	// update generator state: a running clock, a held wheel value, held switches
	logic [31:0] clock_ms = 32'd5000;
	int          step_scale = 1;
	int          wheel_val = 0;
	int          wheel_left = 0;
	int          sw_left = 0;
	logic [1:0]  clr_sel = amaf_pkg::POS_CENTER;
	logic [1:0]  gear_sel = amaf_pkg::POS_CENTER;
	int          thr_mirror [4] = '{500, 300, -500, -300};

	// receiver side
	logic [31:0] rx_cycle = '0;
	logic [15:0] ready_pat = 16'hFFFF;
	int          hold_left = 0;
	logic        press_mode = 1'b0;
	logic        press_done = 1'b0;

	adjust_mode_arbiter_fsm_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	adjust_mode_arbiter_fsm_monitor mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: a fresh ready pattern each time rx_cycle[7:0] is zero (sometimes all
	// ones, sometimes sparse). Once press_mode goes high it holds off for a long
	// stretch so both pipeline stages fill and s_axis_tready drops.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle[7:0] == 8'd0) begin
			case ($urandom_range(0, 3))
				0: ready_pat <= 16'hFFFF;
				1: ready_pat <= 16'($urandom) | 16'h0001;
				2: ready_pat <= 16'($urandom & $urandom) | 16'h0001;
				default: ready_pat <= 16'($urandom | $urandom);
			endcase
		end
		if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (press_mode && !press_done) begin
			press_done    <= 1'b1;
			hold_left     <= 80;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ready_pat[rx_cycle[3:0]];
		end
	end

	// update with home centered and every precondition met
	function automatic amaf_pkg::item_t go_update(logic [31:0] t, int tv);
		amaf_pkg::item_t u;
		u                 = '0;
		u.now_ms          = t;
		u.home_pos        = amaf_pkg::POS_CENTER;
		u.clearance_pos   = amaf_pkg::POS_CENTER;
		u.gear_pos        = amaf_pkg::POS_CENTER;
		u.track_value     = 11'(tv);
		u.park_selected   = 1'b1;
		u.at_zero_speed   = 1'b1;
		u.throttle_is_low = 1'b1;
		return u;
	endfunction

	// One beat out; between bursts the sender may go quiet for a while.
	// tvalid stays up across back-to-back beats of a burst.
	task automatic send_beat(input amaf_pkg::item_t u);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= u;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	// Stop offering and wait for every predicted result to come back. The
	// first edge lets the monitor's count catch up with the last beat.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// All six registers plus one write to an unused index. Threshold writes
	// carry junk in the upper bits, which the block must ignore.
	task automatic write_regs(input logic [15:0] ee, er, re, rr, st, ce);
		cfg_wr_en <= 1'b1;
		cfg_index <= amaf_pkg::CFG_EXTEND_ENGAGE;
		cfg_data  <= {5'($urandom), ee[10:0]};
		@(posedge clk);
		cfg_index <= amaf_pkg::CFG_EXTEND_RELEASE;
		cfg_data  <= {5'($urandom), er[10:0]};
		@(posedge clk);
		cfg_index <= amaf_pkg::CFG_RETRACT_ENGAGE;
		cfg_data  <= {5'($urandom), re[10:0]};
		@(posedge clk);
		cfg_index <= amaf_pkg::CFG_RETRACT_RELEASE;
		cfg_data  <= {5'($urandom), rr[10:0]};
		@(posedge clk);
		cfg_index <= amaf_pkg::CFG_STABLE_TIME;
		cfg_data  <= st;
		@(posedge clk);
		cfg_index <= amaf_pkg::CFG_CENTER_EXIT;
		cfg_data  <= ce;
		@(posedge clk);
		cfg_index <= CFG_SPARE_IDX;
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_mirror[0] = int'($signed(ee[10:0]));
		thr_mirror[1] = int'($signed(er[10:0]));
		thr_mirror[2] = int'($signed(re[10:0]));
		thr_mirror[3] = int'($signed(rr[10:0]));
	endtask

	// Mostly well-formed updates: time moves forward in small steps, the
	// wheel and the switches hold a value for a while so directions can
	// settle and owners persist. A minority breaks home or preconditions.
	task automatic next_random_update(output amaf_pkg::item_t u);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			clock_ms += 32'(step_scale) * $urandom_range(0, 30);
		else if (pick < 95)
			clock_ms += 32'(step_scale) * $urandom_range(30, 300);
		else if (pick < 98)
			clock_ms += $urandom_range(0, 70000);
		else if (pick < 99)
			clock_ms = $urandom;   // arbitrary jump, also backwards

		if (wheel_left == 0) begin
			wheel_left = $urandom_range(1, 12);
			case ($urandom_range(0, 5))
				0: wheel_val = $urandom_range(0, 60) - 30;
				1: wheel_val = $urandom_range(500, 1023);
				2: wheel_val = -$urandom_range(500, 1024);
				3: wheel_val = $urandom_range(0, 2047) - 1024;
				default: wheel_val = thr_mirror[$urandom_range(0, 3)] + $urandom_range(0, 40) - 20;
			endcase
		end else begin
			wheel_left--;
			if ($urandom_range(0, 3) == 0) wheel_val += $urandom_range(0, 10) - 5;
		end

		if (sw_left == 0) begin
			sw_left = $urandom_range(1, 15);
			if ($urandom_range(0, 9) < 6) begin
				clr_sel  = amaf_pkg::POS_CENTER;
				gear_sel = amaf_pkg::POS_CENTER;
			end else begin
				clr_sel  = 2'($urandom);
				gear_sel = 2'($urandom);
			end
		end else begin
			sw_left--;
		end

		u               = go_update(clock_ms, wheel_val);
		u.clearance_pos = clr_sel;
		u.gear_pos      = gear_sel;
		u.at_zero_speed = ($urandom_range(0, 9) < 7);
		u.front_select  = ($urandom_range(0, 9) == 0);
		u.rear_select   = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 99) < 5) u.home_pos = 2'($urandom_range(1, 3));
		if ($urandom_range(0, 99) < 12)
			{u.park_selected, u.throttle_is_low, u.estop_active, u.severe_fault} = 4'($urandom);
	endtask

	task automatic run_phase(int count, int scale);
		amaf_pkg::item_t u;
		step_scale = scale;
		repeat (count) begin
			next_random_update(u);
			send_beat(u);
		end
		drain();
	endtask

	initial begin
		amaf_pkg::item_t u;
		int              e_eng, r_eng;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, at reset register values ----
		u = go_update(32'd10, 0);
		u.home_pos = amaf_pkg::POS_HIGH;    // home off center -> idle
		send_beat(u);
		u = go_update(32'd12, 0);
		u.home_pos = POS_OTHER;             // unknown home position also off center
		send_beat(u);
		u = go_update(32'd20, 0);
		u.park_selected = 1'b0;             // precondition fails -> aborted
		send_beat(u);
		u = go_update(32'd30, 0);
		u.at_zero_speed = 1'b0;             // re-entry from aborted needs zero speed
		send_beat(u);
		send_beat(go_update(32'd40, 0));    // ready
		send_beat(go_update(32'd1000, 600)); // extend candidate
		u = go_update(32'd1050, 600);
		u.at_zero_speed = 1'b0;             // zero speed no longer needed once in
		send_beat(u);
		send_beat(go_update(32'd1100, 600)); // persisted 100 ms -> prepare
		send_beat(go_update(32'd1110, 350)); // held by release level -> active
		send_beat(go_update(32'd1120, 0));  // wheel centered -> exiting
		send_beat(go_update(32'd1200, 0));
		send_beat(go_update(32'd1320, 0));  // exit hold over -> ready
		send_beat(go_update(32'd1400, -1024));
		send_beat(go_update(32'd1500, -1024)); // retract latched
		send_beat(go_update(32'd1510, -350));
		u = go_update(32'd1520, -350);
		u.estop_active = 1'b1;
		send_beat(u);
		u = go_update(32'd1530, 0);
		u.severe_fault = 1'b1;
		send_beat(u);
		u = go_update(32'd1540, 0);
		u.throttle_is_low = 1'b0;
		send_beat(u);
		u = go_update(32'd1550, 0);
		u.gear_pos     = amaf_pkg::POS_LOW; // hydraulic owner
		u.front_select = 1'b1;              // both selects: rear wins
		u.rear_select  = 1'b1;
		send_beat(u);
		u = go_update(32'd1560, 0);
		u.gear_pos      = POS_OTHER;        // other position does not request
		u.clearance_pos = amaf_pkg::POS_HIGH; // clearance owner
		send_beat(u);
		u = go_update(32'd1570, 0);
		u.clearance_pos = POS_OTHER;
		u.front_select  = 1'b1;
		send_beat(u);
		// persistence measured across the 32-bit time wrap
		send_beat(go_update(32'hFFFF_FFF0, 1023));
		send_beat(go_update(32'h0000_0050, 1023));
		send_beat(go_update(32'h0000_0054, 1023));
		// exit stamp taken at time zero reads as "not taken" and is retaken
		send_beat(go_update(32'd0, 0));
		send_beat(go_update(32'd150, 0));
		send_beat(go_update(32'd350, 0));
		drain();

		// ---- random phases over several register settings ----
		write_regs(16'(400), 16'(250), 16'(-400), 16'(-250), 16'd40, 16'd60);
		run_phase(400, 1);

		// no persistence, no exit hold, no hysteresis band
		write_regs(16'(200), 16'(200), 16'(-200), 16'(-200), 16'd0, 16'd0);
		run_phase(300, 1);

		// register extremes; time steps scaled up so the long timers expire
		write_regs(16'(1023), 16'(-1024), 16'(-1024), 16'(1023), 16'hFFFF, 16'hFFFF);
		run_phase(250, 3000);

		// arbitrary register contents, with the long receiver hold-off
		write_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		press_mode <= 1'b1;
		run_phase(400, $urandom_range(1, 400));

		e_eng = $urandom_range(100, 900);
		r_eng = $urandom_range(100, 900);
		write_regs(16'(e_eng), 16'(e_eng - int'($urandom_range(0, 300))),
			16'(-r_eng), 16'(-r_eng + int'($urandom_range(0, 300))),
			16'($urandom_range(0, 150)), 16'($urandom_range(0, 250)));
		run_phase(350, 1);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
